// ===== rtl/lrpg_pkg.sv =====
package lrpg_pkg;

  // Default coordinate width of the endpoints and emitted points.
  localparam int COORD_BITS_DEFAULT = 16;

  // Canvas registers, color and framebuffer index widths.
  localparam int REG_BITS   = 13;
  localparam int COLOR_BITS = 32;
  localparam int INDEX_BITS = 24;
  localparam int CFG_ADDR_BITS = 1;

  localparam logic [REG_BITS-1:0] CANVAS_WIDTH_RESET  = 13'd960;
  localparam logic [REG_BITS-1:0] CANVAS_HEIGHT_RESET = 13'd640;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input item kinds carried in the slave-side tuser.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Handshake between the stepping stage and the pixel stage.
  typedef struct packed {
    logic valid;
    logic last;
  } pt_flags_t;

endpackage

// ===== rtl/lrpg_step.sv =====
module lrpg_step #(
  parameter int CB = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic signed [CB-1:0]            in_x0,
  input  logic signed [CB-1:0]            in_y0,
  input  logic signed [CB-1:0]            in_x1,
  input  logic signed [CB-1:0]            in_y1,
  input  logic [lrpg_pkg::COLOR_BITS-1:0] in_color,
  input  logic                            pt_take,
  output lrpg_pkg::pt_flags_t             pt_flags,
  output logic signed [CB-1:0]            pt_x,
  output logic signed [CB-1:0]            pt_y,
  output logic [lrpg_pkg::COLOR_BITS-1:0] pt_color
);
  import lrpg_pkg::*;

  logic signed [CB-1:0]   cur_x, cur_y, target_x, target_y;
  logic [CB-1:0]          abs_dx;
  logic signed [CB:0]     neg_abs_dy;
  logic                   step_x_negative, step_y_negative;
  logic signed [CB+1:0]   error_term;
  logic [COLOR_BITS-1:0]  held_color;
  logic                   line_active;

  logic signed [CB-1:0]   cur_x_next, cur_y_next, target_x_next, target_y_next;
  logic [CB-1:0]          abs_dx_next;
  logic signed [CB:0]     neg_abs_dy_next;
  logic                   step_x_negative_next, step_y_negative_next;
  logic signed [CB+1:0]   error_term_next;
  logic [COLOR_BITS-1:0]  held_color_next;

  logic                   accept, is_start, produce, last_next;
  logic signed [CB:0]     dx, dy;
  logic signed [CB+2:0]   doubled, neg_wide, abs_wide;
  logic                   move_x, move_y;

  assign in_ready = !pt_flags.valid || pt_take;
  assign accept   = in_valid && in_ready;
  assign is_start = (action_t'(in_action) == ACT_START);
  assign produce  = accept && (is_start || line_active);

  assign dx = {in_x1[CB-1], in_x1} - {in_x0[CB-1], in_x0};
  assign dy = {in_y1[CB-1], in_y1} - {in_y0[CB-1], in_y0};

  // Doubled error is tested before either correction is applied.
  assign doubled  = {error_term, 1'b0};
  assign neg_wide = {{2{neg_abs_dy[CB]}}, neg_abs_dy};
  assign abs_wide = $signed({3'b000, abs_dx});
  assign move_x   = (doubled >= neg_wide);
  assign move_y   = (doubled <= abs_wide);

  always_comb begin
    cur_x_next           = cur_x;
    cur_y_next           = cur_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    abs_dx_next          = abs_dx;
    neg_abs_dy_next      = neg_abs_dy;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    error_term_next      = error_term;
    held_color_next      = held_color;
    if (is_start) begin
      cur_x_next           = in_x0;
      cur_y_next           = in_y0;
      target_x_next        = in_x1;
      target_y_next        = in_y1;
      abs_dx_next          = dx[CB] ? CB'(-dx) : dx[CB-1:0];
      neg_abs_dy_next      = dy[CB] ? dy : -dy;
      step_x_negative_next = !(dx > 0);
      step_y_negative_next = !(dy > 0);
      error_term_next      = $signed({2'b00, abs_dx_next})
                             + {neg_abs_dy_next[CB], neg_abs_dy_next};
      held_color_next      = in_color;
    end else begin
      error_term_next = error_term
                        + (move_x ? neg_wide[CB+1:0] : '0)
                        + (move_y ? abs_wide[CB+1:0] : '0);
      if (move_x) begin
        cur_x_next = step_x_negative ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y_next = step_y_negative ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  assign last_next = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      target_x        <= '0;
      target_y        <= '0;
      abs_dx          <= '0;
      neg_abs_dy      <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      error_term      <= '0;
      held_color      <= '0;
      line_active     <= 1'b0;
      pt_flags        <= '0;
    end else begin
      if (produce) begin
        cur_x           <= cur_x_next;
        cur_y           <= cur_y_next;
        target_x        <= target_x_next;
        target_y        <= target_y_next;
        abs_dx          <= abs_dx_next;
        neg_abs_dy      <= neg_abs_dy_next;
        step_x_negative <= step_x_negative_next;
        step_y_negative <= step_y_negative_next;
        error_term      <= error_term_next;
        held_color      <= held_color_next;
        line_active     <= !last_next;
        pt_flags.valid  <= 1'b1;
        pt_flags.last   <= last_next;
      end else if (pt_take) begin
        pt_flags.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      pt_x     <= cur_x_next;
      pt_y     <= cur_y_next;
      pt_color <= held_color_next;
    end
  end

`ifndef SYNTHESIS
  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    accept && is_start |=> pt_flags.valid)
    else $error("start beat did not produce a point");
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    $past(produce) && pt_flags.last |-> !line_active)
    else $error("line still active after its last point");
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !is_start && !line_active |=> !pt_flags.valid)
    else $error("step without an active line produced a point");
`endif

endmodule

// ===== rtl/lrpg_pixel.sv =====
module lrpg_pixel #(
  parameter int CB = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lrpg_pkg::REG_BITS-1:0]   canvas_width,
  input  logic [lrpg_pkg::REG_BITS-1:0]   canvas_height,
  input  lrpg_pkg::pt_flags_t             pt_flags,
  input  logic signed [CB-1:0]            pt_x,
  input  logic signed [CB-1:0]            pt_y,
  input  logic [lrpg_pkg::COLOR_BITS-1:0] pt_color,
  output logic                            pt_take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [CB-1:0]            out_x,
  output logic signed [CB-1:0]            out_y,
  output logic                            out_inside,
  output logic [lrpg_pkg::INDEX_BITS-1:0] out_index,
  output logic [lrpg_pkg::COLOR_BITS-1:0] out_color,
  output logic                            out_last
);
  import lrpg_pkg::*;

  localparam int WW = CB + REG_BITS;

  logic [WW-1:0]           x_wide, y_wide;
  logic                    pt_on_canvas;
  logic [2*REG_BITS-1:0]   row_base;
  logic [2*REG_BITS:0]     index_full;

  assign x_wide = WW'(unsigned'(pt_x));
  assign y_wide = WW'(unsigned'(pt_y));

  assign pt_on_canvas = !pt_x[CB-1] && !pt_y[CB-1]
                        && (x_wide < WW'(canvas_width))
                        && (y_wide < WW'(canvas_height));

  // Inside the canvas both coordinates fit the register width.
  assign row_base   = y_wide[REG_BITS-1:0] * canvas_width;
  assign index_full = {1'b0, row_base} + (2*REG_BITS+1)'(x_wide[REG_BITS-1:0]);

  assign pt_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pt_take) begin
      out_valid <= pt_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_take && pt_flags.valid) begin
      out_x      <= pt_x;
      out_y      <= pt_y;
      out_inside <= pt_on_canvas;
      out_index  <= pt_on_canvas ? index_full[INDEX_BITS-1:0] : '0;
      out_color  <= pt_color;
      out_last   <= pt_flags.last;
    end
  end

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_inside |-> out_index == '0)
    else $error("outside point carries a nonzero index");
  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_inside |-> !out_x[CB-1] && !out_y[CB-1])
    else $error("negative coordinate flagged inside the canvas");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("stalled point changed");
`endif

endmodule

// ===== rtl/line_raster_pixel_generator_core.sv =====
// Channel   | Beat contents                                          | Handshake
// s_axis    | tdata: start_x, start_y, end_x, end_y, line_color      | s_tvalid/s_tready
//           | tuser: action (0 start, 1 step)                        |
// m_axis    | tdata: pixel_x, pixel_y, pixel_index, pixel_color      | m_tvalid/m_tready
//           | tuser: in_canvas, tlast: last_point                    |
// cfg       | canvas_width (index 0), canvas_height (index 1)        | cfg_wr_en
//
// The block takes one beat per clock unless the master side stalls, and emits
// at most one pixel per beat. A pixel reaches the master side through two
// registered stages: the stepping stage updates the Bresenham state, the pixel
// stage clips the point and forms y*width+x with one 13x13 multiply. A stall
// on the master side backs up through the two stages; each stage refills as
// soon as it drains. Reset clears all line state and valids and restores a 960x640 canvas.
module line_raster_pixel_generator_core #(
  parameter int COORD_BITS = lrpg_pkg::COORD_BITS_DEFAULT,
  localparam int IN_W  = ((4 * COORD_BITS + lrpg_pkg::COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + lrpg_pkg::INDEX_BITS
                           + lrpg_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [IN_W-1:0]                    s_tdata,
  // action
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pixel_x, pixel_y, pixel_index, pixel_color, zero pad
  output logic [OUT_W-1:0]                   m_tdata,
  // in_canvas
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_wr_en,
  input  logic [lrpg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [lrpg_pkg::REG_BITS-1:0]      cfg_data
);
  import lrpg_pkg::*;

  localparam int CB = COORD_BITS;

  logic [REG_BITS-1:0]   canvas_width, canvas_height;
  pt_flags_t             pt_flags;
  logic signed [CB-1:0]  pt_x, pt_y, out_x, out_y;
  logic [COLOR_BITS-1:0] pt_color, out_color;
  logic [INDEX_BITS-1:0] out_index;
  logic                  pt_take;

  // Canvas registers; the user must write them only while no line is in flight, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_WIDTH_RESET;
      canvas_height <= CANVAS_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lrpg_step #(.CB(CB)) u_step (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_action(s_tuser),
    .in_x0    (s_tdata[CB-1:0]),
    .in_y0    (s_tdata[2*CB-1:CB]),
    .in_x1    (s_tdata[3*CB-1:2*CB]),
    .in_y1    (s_tdata[4*CB-1:3*CB]),
    .in_color (s_tdata[4*CB+COLOR_BITS-1:4*CB]),
    .pt_take  (pt_take),
    .pt_flags (pt_flags),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_color (pt_color)
  );

  lrpg_pixel #(.CB(CB)) u_pixel (
    .clk          (clk),
    .rst          (rst),
    .canvas_width (canvas_width),
    .canvas_height(canvas_height),
    .pt_flags     (pt_flags),
    .pt_x         (pt_x),
    .pt_y         (pt_y),
    .pt_color     (pt_color),
    .pt_take      (pt_take),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_inside   (m_tuser),
    .out_index    (out_index),
    .out_color    (out_color),
    .out_last     (m_tlast)
  );

  assign m_tdata = OUT_W'({out_color, out_index, out_y, out_x});

endmodule

// ===== tb/line_raster_pixel_checker.sv =====
module line_raster_pixel_checker
  import lrpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int IN_W  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
  parameter int OUT_W = ((2 * COORD_BITS + INDEX_BITS + COLOR_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [IN_W-1:0]          s_tdata,
  // action
  input  logic                     s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  // pixel_x, pixel_y, pixel_index, pixel_color
  input  logic [OUT_W-1:0]         m_tdata,
  // in_canvas
  input  logic                     m_tuser,
  input  logic                     m_tlast,
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [REG_BITS-1:0]      cfg_data,
  output int                       pixels_pending,
  output int                       mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic                   on_canvas;
    logic [INDEX_BITS-1:0]  index;
    logic [COLOR_BITS-1:0]  color;
    logic                   is_last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // Canvas size and the Bresenham walk of the line being drawn.
  int canvas_w;
  int canvas_h;
  int cur_x;
  int cur_y;
  int dest_x;
  int dest_y;
  int run_x;
  int rise_neg;
  int err_acc;
  logic x_back;
  logic y_back;
  logic drawing;
  logic [COLOR_BITS-1:0] line_color;

  function automatic pixel_t plot_current();
    pixel_t p;
    int lin;
    p.x = cur_x[CW-1:0];
    p.y = cur_y[CW-1:0];
    p.on_canvas = cur_x >= 0 && cur_y >= 0 && cur_x < canvas_w && cur_y < canvas_h;
    lin = cur_y * canvas_w + cur_x;
    p.index = p.on_canvas ? lin[INDEX_BITS-1:0] : '0;
    p.color = line_color;
    p.is_last = (cur_x == dest_x) && (cur_y == dest_y);
    // Reaching the end point closes the line.
    if (p.is_last) drawing = 1'b0;
    return p;
  endfunction

  task automatic predict_beat(input logic act, input logic [IN_W-1:0] d);
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    int twice;
    if (act == ACT_START) begin
      x0 = d[CW-1:0];
      y0 = d[2*CW-1:CW];
      x1 = d[3*CW-1:2*CW];
      y1 = d[4*CW-1:3*CW];
      cur_x = x0;
      cur_y = y0;
      dest_x = x1;
      dest_y = y1;
      run_x = (dest_x > cur_x) ? dest_x - cur_x : cur_x - dest_x;
      rise_neg = (dest_y > cur_y) ? cur_y - dest_y : dest_y - cur_y;
      x_back = !(cur_x < dest_x);
      y_back = !(cur_y < dest_y);
      err_acc = run_x + rise_neg;
      line_color = d[4*CW+COLOR_BITS-1:4*CW];
      drawing = 1'b1;
      expected_pixels.push_back(plot_current());
    end else if (drawing) begin
      // Both decisions use the doubled error taken before either update.
      twice = 2 * err_acc;
      if (twice >= rise_neg) begin
        err_acc += rise_neg;
        cur_x += x_back ? -1 : 1;
      end
      if (twice <= run_x) begin
        err_acc += run_x;
        cur_y += y_back ? -1 : 1;
      end
      expected_pixels.push_back(plot_current());
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    pixel_t got;
    got.x = m_tdata[CW-1:0];
    got.y = m_tdata[2*CW-1:CW];
    got.on_canvas = m_tuser;
    got.index = m_tdata[2*CW+INDEX_BITS-1:2*CW];
    got.color = m_tdata[2*CW+INDEX_BITS+COLOR_BITS-1:2*CW+INDEX_BITS];
    got.is_last = m_tlast;
    if (expected_pixels.size() == 0) begin
      $error("pixel beat with nothing expected: x=%0d y=%0d", got.x, got.y);
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
        mismatches++;
      end
      if (got.on_canvas !== want.on_canvas) begin
        $error("in_canvas: expected %0d, actual %0d", want.on_canvas, got.on_canvas);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $error("pixel_index: expected %0d, actual %0d", want.index, got.index);
        mismatches++;
      end
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, actual %h", want.color, got.color);
        mismatches++;
      end
      if (got.is_last !== want.is_last) begin
        $error("last_point: expected %0d, actual %0d", want.is_last, got.is_last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      canvas_w = CANVAS_WIDTH_RESET;
      canvas_h = CANVAS_HEIGHT_RESET;
      cur_x = 0;
      cur_y = 0;
      dest_x = 0;
      dest_y = 0;
      run_x = 0;
      rise_neg = 0;
      err_acc = 0;
      x_back = 1'b0;
      y_back = 1'b0;
      drawing = 1'b0;
      line_color = '0;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_CANVAS_WIDTH: canvas_w = cfg_data;
          REG_CANVAS_HEIGHT: canvas_h = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_pixel();
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// ===== tb/line_raster_pixel_generator_core_test.sv =====
// Top of the line rasterizer bench. This module only makes stimulus and gives
// the verdict; the checker beside the block predicts every pixel and compares.
module line_raster_pixel_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lrpg_pkg::*;

  localparam int CW    = COORD_BITS_DEFAULT;
  localparam int IN_W  = ((4 * CW + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + INDEX_BITS + COLOR_BITS + 7) / 8) * 8;
  // Cycles the receiver refuses beats in one go, so the pipeline backs up.
  localparam int HOLD_OFF = 300;
  // Cycles without any beat on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;    // start_x, start_y, end_x, end_y, line_color
  logic s_tuser;               // action
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;   // pixel_x, pixel_y, pixel_index, pixel_color
  logic m_tuser;               // in_canvas
  logic m_tlast;
  logic cfg_wr_en;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [REG_BITS-1:0] cfg_data;

  int pixels_pending;
  int mismatches;
  int quiet_cycles = 0;

  // Beats that drive the block (starts and steps on a live line).
  int live_beats = 0;
  // Set for the closing phase: neither side idles any more.
  logic calm;
  // Asks the receiver for its one long hold-off.
  logic hold_req;
  bit hold_done = 1'b0;
  // Chosen per line: whether the sender may insert gaps before its beats.
  bit pause_ok;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_raster_pixel_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  line_raster_pixel_checker pixel_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .pixels_pending(pixels_pending),
    .mismatches    (mismatches)
  );

  // Offers one beat and returns at the edge where it is taken. The valid is
  // left high, so a following beat goes out without a gap unless a pause is
  // drawn. Handshakes are sampled at the edge, before any update lands.
  task automatic send_beat(input action_t act, input logic [IN_W-1:0] data);
    if (!calm && pause_ok && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                            input logic [COLOR_BITS-1:0] color);
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    ax = CW'(x0);
    ay = CW'(y0);
    bx = CW'(x1);
    by = CW'(y1);
    send_beat(ACT_START, {color, by, bx, ay, ax});
    live_beats++;
  endtask

  // Step beats carry random payload, which the block must ignore. Steps past
  // the end of a line (live == 0) produce nothing and are not counted.
  task automatic step_line(input int n, input bit live);
    repeat (n) send_beat(ACT_STEP, {$urandom, $urandom, $urandom});
    if (live) live_beats += n;
  endtask

  // Lets every predicted pixel drain, then allows for the pipeline latency in
  // case the last beats were steps that produce no pixel.
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pixels_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_CANVAS_WIDTH;
    cfg_data <= REG_BITS'(w);
    @(posedge clk);
    cfg_addr <= REG_CANVAS_HEIGHT;
    cfg_data <= REG_BITS'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int clamp(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int any_coord();
    logic signed [CW-1:0] r;
    r = CW'($urandom);
    return r;
  endfunction

  // Coordinates that cluster on both edges of a canvas dimension, so that
  // clipping flips inside a line.
  function automatic int near(input int lim);
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 6) - 3;
      1: return lim + $urandom_range(0, 6) - 3;
      default: return $urandom_range(0, lim + 2) - 1;
    endcase
  endfunction

  // Number of steps after the first point: Bresenham takes the larger axis.
  function automatic int line_steps(input int x0, input int y0, input int x1, input int y1);
    int ax;
    int ay;
    ax = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay = (y1 > y0) ? y1 - y0 : y0 - y1;
    return (ax > ay) ? ax : ay;
  endfunction

  // One random line. Most are run to their end; some are cut short and
  // abandoned by the next start, some get stray steps after the end.
  task automatic random_line(input int w, input int h);
    int x0;
    int y0;
    int x1;
    int y1;
    int spread;
    int len;
    spread = 12;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        // Anywhere in the coordinate range, so every bit toggles.
        x0 = any_coord();
        y0 = any_coord();
      end
      4: begin
        x0 = near(w);
        y0 = near(h);
        spread = 300;
      end
      default: begin
        x0 = near(w);
        y0 = near(h);
      end
    endcase
    x1 = clamp(x0 + $urandom_range(0, 2 * spread) - spread);
    y1 = clamp(y0 + $urandom_range(0, 2 * spread) - spread);
    len = line_steps(x0, y0, x1, y1);
    pause_ok = $urandom_range(0, 1);
    start_line(x0, y0, x1, y1, $urandom);
    case ($urandom_range(0, 9))
      0: step_line($urandom_range(0, len), 1'b1);
      1: begin
        step_line(len, 1'b1);
        step_line($urandom_range(1, 3), 1'b0);
      end
      default: step_line(len, 1'b1);
    endcase
  endtask

  // Lines across the far corner and around the origin of the canvas.
  task automatic corner_lines(input int w, input int h);
    start_line(w - 1, h - 1, w + 1, h - 2, $urandom);
    step_line(2, 1'b1);
    start_line(-1, -1, 1, 1, $urandom);
    step_line(2, 1'b1);
  endtask

  // Canvas settings of the later phases, the register extremes among them.
  int phase_w[7] = '{37, 1, 4096, 0, 8191, 5, 960};
  int phase_h[7] = '{23, 1, 4096, 7, 8191, 0, 640};

  initial begin
    int goal;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= ACT_START;
    s_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_CANVAS_WIDTH;
    cfg_data <= '0;
    calm <= 1'b0;
    hold_req <= 1'b0;
    pause_ok = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset canvas of 960x640.
    // A step right after reset has no line to advance.
    step_line(1, 1'b0);
    // Endpoints at the extremes of the coordinate range; each line is
    // abandoned after two steps by the next start.
    start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h0000_0000);
    step_line(2, 1'b1);
    start_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 32'hFFFF_FFFF);
    step_line(2, 1'b1);
    // Equal endpoints give a single last point; the step after it is idle.
    start_line(5, 5, 5, 5, 32'hA5A5_A5A5);
    step_line(1, 1'b0);
    // A shallow line, then one step past its end.
    start_line(0, 0, 3, 1, $urandom);
    step_line(3, 1'b1);
    step_line(1, 1'b0);
    // Leaving the canvas through its far corner with y falling.
    start_line(959, 639, 961, 636, $urandom);
    step_line(3, 1'b1);
    // A steep line with x falling.
    start_line(10, 3, 7, 7, $urandom);
    step_line(4, 1'b1);

    // Random part on the reset canvas. The receiver takes its long hold-off
    // here while the sender keeps offering beats.
    hold_req <= 1'b1;
    goal = live_beats + 160;
    while (live_beats < goal) random_line(CANVAS_WIDTH_RESET, CANVAS_HEIGHT_RESET);

    // Canvas changes only once the block is empty.
    for (int p = 0; p < 7; p++) begin
      drain_pixels();
      set_canvas(phase_w[p], phase_h[p]);
      if (p == 6) calm <= 1'b1;
      corner_lines(phase_w[p], phase_h[p]);
      goal = live_beats + 40;
      while (live_beats < goal) random_line(phase_w[p], phase_h[p]);
    end

    drain_pixels();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stretches of readiness broken by short stalls, one long
  // hold-off on request, and no stalls at all in the closing phase.
  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
